// ----- rtl/three_class_priority_queue_macros.svh -----
// Assertion macros for the priority queue checker.
`ifndef THREE_CLASS_PRIORITY_QUEUE_MACROS_SVH
`define THREE_CLASS_PRIORITY_QUEUE_MACROS_SVH

// Implication checked in the same cycle.
`define TCPQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tcpq: same-cycle check failed");

// Implication checked in the next cycle.
`define TCPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tcpq: next-cycle check failed");

`endif

// ----- rtl/tcpq_pkg.sv -----
// Types and constants for the three-class priority queue.
package tcpq_pkg;

    // Urgency classes, most urgent first
    typedef enum logic [1:0] {
        CLS_RED    = 2'd0,
        CLS_YELLOW = 2'd1,
        CLS_GREEN  = 2'd2
    } class_t;

    // Operation codes on the func port
    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_REMOVE = 1'b1;

    localparam int COUNT_W = 5;
    localparam int ENTRY_ID_W = 16;

    // Occupancy and class of one slot
    typedef struct packed {
        logic   valid;
        class_t cls;
    } slot_tag_t;

    // Command broadcast to every cell
    typedef struct packed {
        logic   ins;
        logic   rem;
        class_t cls;
    } cell_op_t;

    // Match ripple along the row, head to tail
    typedef struct packed {
        logic   hit;
        class_t cls;
    } match_chain_t;

    // Maps the raw urgency code; code three counts as green
    function automatic class_t to_class(input logic [1:0] code);
        class_t c;
        c = (code == 2'd3) ? CLS_GREEN : class_t'(code);
        return c;
    endfunction

endpackage

// ----- rtl/tcpq_cell.sv -----
// One slot of the queue: holds an entry, shifts toward tail on insert or head on remove.
module tcpq_cell #(
    parameter int SID_W = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  tcpq_pkg::cell_op_t    op,
    input  logic [SID_W-1:0]      op_id,
    input  tcpq_pkg::slot_tag_t   prev_tag,
    input  logic [SID_W-1:0]      prev_id,
    input  tcpq_pkg::slot_tag_t   next_tag,
    input  logic [SID_W-1:0]      next_id,
    input  tcpq_pkg::match_chain_t chain_in,
    output tcpq_pkg::slot_tag_t   tag,
    output logic [SID_W-1:0]      id,
    output tcpq_pkg::match_chain_t chain_out
);
    import tcpq_pkg::*;

    logic             valid_reg, valid_next;
    class_t           cls_reg, cls_next;
    logic [SID_W-1:0] id_reg, id_next;
    logic             ins_shift, ins_place, match, take;

    // Local decisions; the queue is kept sorted by class, so neighbors suffice
    always_comb
    begin
        ins_shift = op.ins && prev_tag.valid && (prev_tag.cls > op.cls);
        ins_place = op.ins && prev_tag.valid && (prev_tag.cls <= op.cls)
                    && (!valid_reg || (cls_reg > op.cls));
        match     = valid_reg && (id_reg == op_id);
        take      = op.rem && (chain_in.hit || match);
        chain_out.hit = chain_in.hit || match;
        chain_out.cls = chain_in.hit ? chain_in.cls : cls_reg;
    end

    // Next slot contents
    always_comb
    begin
        valid_next = valid_reg;
        cls_next   = cls_reg;
        id_next    = id_reg;
        priority if (ins_shift)
        begin
            valid_next = 1'b1;
            cls_next   = prev_tag.cls;
            id_next    = prev_id;
        end
        else if (ins_place)
        begin
            valid_next = 1'b1;
            cls_next   = op.cls;
            id_next    = op_id;
        end
        else if (take)
        begin
            valid_next = next_tag.valid;
            cls_next   = next_tag.cls;
            id_next    = next_id;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload, no reset
    always_ff @(posedge clk)
    begin
        cls_reg <= cls_next;
        id_reg  <= id_next;
    end

    assign tag.valid = valid_reg;
    assign tag.cls   = cls_reg;
    assign id        = id_reg;

endmodule

// ----- rtl/three_class_priority_queue.sv -----
// Three-class stable priority queue built as a row of DEPTH shifting cells.
// Latency: the result strobe rises in the cycle after a request is taken.
// Throughput: one request per cycle; busy stays low, and all cells update on the same edge.
// The remove search ripples a match flag through all DEPTH cells in the cycle the request is taken.
// Reset clears all valid bits, the class counts and the strobe; ids are not cleared.
module three_class_priority_queue #(
    parameter int DEPTH   = 16,
    parameter int ID_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          func,
    input  logic [tcpq_pkg::ENTRY_ID_W-1:0] entry_id,
    input  logic [1:0]                    urgency,
    output logic                          done,
    output logic                          accepted,
    output logic                          found,
    output logic [tcpq_pkg::COUNT_W-1:0]  red_count,
    output logic [tcpq_pkg::COUNT_W-1:0]  yellow_count,
    output logic [tcpq_pkg::COUNT_W-1:0]  green_count
);
    import tcpq_pkg::*;

    localparam int SID_W = (ID_BITS < ENTRY_ID_W) ? ID_BITS : ENTRY_ID_W;

    slot_tag_t        tags  [DEPTH];
    logic [SID_W-1:0] ids   [DEPTH];
    match_chain_t     chain [DEPTH];
    slot_tag_t        head_tag, tail_tag;
    match_chain_t     chain_head;
    cell_op_t         op;
    logic [SID_W-1:0] op_id;
    logic             take_req, full;

    logic                done_reg, done_next;
    logic                accepted_reg, accepted_next;
    logic                found_reg, found_next;
    logic [COUNT_W-1:0]  red_reg, red_next;
    logic [COUNT_W-1:0]  yellow_reg, yellow_next;
    logic [COUNT_W-1:0]  green_reg, green_next;
    class_t              upd_cls;
    logic                inc, dec;

    assign busy     = 1'b0;
    assign take_req = start && !busy;
    assign full     = tags[DEPTH-1].valid;
    assign op_id    = entry_id[SID_W-1:0];

    // Command to the row
    always_comb
    begin
        op.ins = take_req && (func == FUNC_INSERT) && !full;
        op.rem = take_req && (func == FUNC_REMOVE);
        op.cls = to_class(urgency);
    end

    // Head sentinel: valid red, so the head cell may take a new entry and never shifts in
    assign head_tag.valid   = 1'b1;
    assign head_tag.cls     = CLS_RED;
    assign tail_tag.valid   = 1'b0;
    assign tail_tag.cls     = CLS_RED;
    assign chain_head.hit   = 1'b0;
    assign chain_head.cls   = CLS_RED;

    // Row of cells
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        tcpq_cell #(
            .SID_W(SID_W)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .op       (op),
            .op_id    (op_id),
            .prev_tag ((i == 0) ? head_tag : tags[(i == 0) ? 0 : i-1]),
            .prev_id  ((i == 0) ? '0 : ids[(i == 0) ? 0 : i-1]),
            .next_tag ((i == DEPTH-1) ? tail_tag : tags[(i == DEPTH-1) ? i : i+1]),
            .next_id  ((i == DEPTH-1) ? ids[i] : ids[(i == DEPTH-1) ? i : i+1]),
            .chain_in ((i == 0) ? chain_head : chain[(i == 0) ? 0 : i-1]),
            .tag      (tags[i]),
            .id       (ids[i]),
            .chain_out(chain[i])
        );
    end

    // Result and class counts
    always_comb
    begin
        done_next     = take_req;
        accepted_next = done_next ? op.ins : accepted_reg;
        found_next    = done_next ? (op.rem && chain[DEPTH-1].hit) : found_reg;
        inc           = op.ins;
        dec           = op.rem && chain[DEPTH-1].hit;
        upd_cls       = inc ? op.cls : chain[DEPTH-1].cls;
        red_next      = red_reg;
        yellow_next   = yellow_reg;
        green_next    = green_reg;
        if (inc || dec)
        begin
            unique case (upd_cls)
                CLS_RED:    red_next    = inc ? red_reg + 1'b1 : red_reg - 1'b1;
                CLS_YELLOW: yellow_next = inc ? yellow_reg + 1'b1 : yellow_reg - 1'b1;
                CLS_GREEN:  green_next  = inc ? green_reg + 1'b1 : green_reg - 1'b1;
                default:    red_next    = red_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg     <= 1'b0;
            accepted_reg <= 1'b0;
            found_reg    <= 1'b0;
            red_reg      <= '0;
            yellow_reg   <= '0;
            green_reg    <= '0;
        end
        else
        begin
            done_reg     <= done_next;
            accepted_reg <= accepted_next;
            found_reg    <= found_next;
            red_reg      <= red_next;
            yellow_reg   <= yellow_next;
            green_reg    <= green_next;
        end
    end

    assign done         = done_reg;
    assign accepted     = accepted_reg;
    assign found        = found_reg;
    assign red_count    = red_reg;
    assign yellow_count = yellow_reg;
    assign green_count  = green_reg;

endmodule

// ----- rtl/tcpq_checker.sv -----
// Port-level checker for the priority queue, bound to the top level.
`include "three_class_priority_queue_macros.svh"

module tcpq_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            start,
    input logic                            busy,
    input logic                            done,
    input logic                            accepted,
    input logic                            found,
    input logic [tcpq_pkg::COUNT_W-1:0]    red_count,
    input logic [tcpq_pkg::COUNT_W-1:0]    yellow_count,
    input logic [tcpq_pkg::COUNT_W-1:0]    green_count
);
    import tcpq_pkg::*;

    // Every taken request gives exactly one result, in the next cycle
    `TCPQ_ASSERT_NEXT(a_req_gives_result, clk, rst_n, start && !busy, done)
    `TCPQ_ASSERT_NEXT(a_no_req_no_result, clk, rst_n, !(start && !busy), !done)
    // An operation cannot both store and delete
    `TCPQ_ASSERT_NOW(a_acc_found_excl, clk, rst_n, done, !(accepted && found))
    // Counts move only with a result
    `TCPQ_ASSERT_NOW(a_counts_hold, clk, rst_n, !done,
        $stable({red_count, yellow_count, green_count}))

endmodule

bind three_class_priority_queue tcpq_checker u_tcpq_checker (.*);
